// ----- hw/rtl/swhfd_pkg.sv -----
package swhfd_pkg;

  localparam int unsigned FRAME_WORD_W = 40;
  localparam int unsigned EDGE_CNT_W   = 6;

  // Two leading edges only set the time reference; the remaining forty carry data bits.
  localparam logic [EDGE_CNT_W-1:0] FRAME_EDGES     = 6'd42;
  localparam logic [EDGE_CNT_W-1:0] FIRST_DATA_EDGE = 6'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd100;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_DELAY = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_EARLY    = 2'd1;
  localparam logic [1:0] ERR_CHECKSUM = 2'd2;

  localparam logic [15:0]        HUM_FAIL  = 16'hffff;
  localparam logic signed [15:0] TEMP_FAIL = -16'sd1;

  typedef struct packed {
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
    logic [1:0]         status;
  } swhfd_result_t;

endpackage

// ----- hw/rtl/swhfd_frame_check.sv -----
module swhfd_frame_check (
  input  logic [swhfd_pkg::FRAME_WORD_W-1:0] frame_word,
  output swhfd_pkg::swhfd_result_t           result,
  output logic                               sum_ok
);
  import swhfd_pkg::*;

  logic [15:0] hum;
  logic [15:0] raw;
  logic [7:0]  check;
  logic [7:0]  sum;
  logic [15:0] temp;

  assign hum   = frame_word[39:24];
  assign raw   = frame_word[23:8];
  assign check = frame_word[7:0];
  assign sum   = hum[15:8] + hum[7:0] + raw[15:8] + raw[7:0];
  assign sum_ok = (sum == check);

  // The sensor sends the temperature as sign and magnitude; negative zero comes out as zero.
  always_comb begin
    if (raw[15]) begin
      temp = 16'd0 - {1'b0, raw[14:0]};
    end else begin
      temp = raw;
    end
  end

  always_comb begin
    if (sum_ok) begin
      result.humidity    = hum;
      result.temperature = $signed(temp);
      result.status      = ERR_NONE;
    end else begin
      result.humidity    = HUM_FAIL;
      result.temperature = TEMP_FAIL;
      result.status      = ERR_CHECKSUM;
    end
  end

endmodule

// ----- hw/rtl/swhfd_edge_state.sv -----
module swhfd_edge_state (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_en,
  input  logic [1:0]               command,
  input  logic [15:0]              edge_time,
  input  logic [15:0]              threshold,
  output logic                     res_valid,
  output swhfd_pkg::swhfd_result_t result
);
  import swhfd_pkg::*;

  logic                    delay_expired_r, delay_expired_nxt;
  logic                    frame_active_r, frame_active_nxt;
  logic [EDGE_CNT_W-1:0]   edge_count_r, edge_count_nxt;
  logic [15:0]             prev_time_r, prev_time_nxt;
  logic [FRAME_WORD_W-1:0] frame_bits_r, frame_bits_nxt;
  logic [15:0]             cached_hum_r, cached_hum_nxt;
  logic signed [15:0]      cached_temp_r, cached_temp_nxt;

  logic [15:0]             spacing;
  logic                    data_bit;
  logic [FRAME_WORD_W-1:0] shifted;
  logic [EDGE_CNT_W-1:0]   count_inc;
  swhfd_result_t           check_res;
  logic                    sum_ok;

  assign spacing   = edge_time - prev_time_r;
  assign data_bit  = (spacing >= threshold);
  assign shifted   = {frame_bits_r[FRAME_WORD_W-2:0], data_bit};
  assign count_inc = edge_count_r + 6'd1;

  // The last edge always carries a data bit, so the shifted word is the complete frame.
  swhfd_frame_check u_check (
    .frame_word (shifted),
    .result     (check_res),
    .sum_ok     (sum_ok)
  );

  always_comb begin
    delay_expired_nxt = delay_expired_r;
    frame_active_nxt  = frame_active_r;
    edge_count_nxt    = edge_count_r;
    prev_time_nxt     = prev_time_r;
    frame_bits_nxt    = frame_bits_r;
    cached_hum_nxt    = cached_hum_r;
    cached_temp_nxt   = cached_temp_r;
    res_valid         = 1'b0;
    result            = check_res;
    if (item_en) begin
      unique case (command)
        CMD_START: begin
          edge_count_nxt = '0;
          if (!delay_expired_r) begin
            frame_active_nxt   = 1'b0;
            res_valid          = 1'b1;
            result.humidity    = cached_hum_r;
            result.temperature = cached_temp_r;
            result.status      = ERR_EARLY;
          end else begin
            delay_expired_nxt = 1'b0;
            frame_active_nxt  = 1'b1;
            frame_bits_nxt    = '0;
          end
        end
        CMD_DELAY: begin
          delay_expired_nxt = 1'b1;
        end
        CMD_EDGE: begin
          if (frame_active_r) begin
            if (edge_count_r >= FIRST_DATA_EDGE) begin
              frame_bits_nxt = shifted;
            end
            prev_time_nxt  = edge_time;
            edge_count_nxt = count_inc;
            if (count_inc >= FRAME_EDGES) begin
              frame_active_nxt = 1'b0;
              res_valid        = 1'b1;
              if (sum_ok) begin
                cached_hum_nxt  = check_res.humidity;
                cached_temp_nxt = check_res.temperature;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_expired_r <= 1'b0;
      frame_active_r  <= 1'b0;
      edge_count_r    <= '0;
      prev_time_r     <= '0;
      frame_bits_r    <= '0;
      cached_hum_r    <= '0;
      cached_temp_r   <= '0;
    end else begin
      delay_expired_r <= delay_expired_nxt;
      frame_active_r  <= frame_active_nxt;
      edge_count_r    <= edge_count_nxt;
      prev_time_r     <= prev_time_nxt;
      frame_bits_r    <= frame_bits_nxt;
      cached_hum_r    <= cached_hum_nxt;
      cached_temp_r   <= cached_temp_nxt;
    end
  end

endmodule

// ----- hw/rtl/single_wire_humidity_frame_decoder_core.sv -----
// An item is registered on acceptance, and its result, if any, is registered from that
// first stage into the output stage, where it can be taken.
// Throughput: one item per cycle; the two-stage pipeline only holds while a result stalls.
// Reset (rst_n low, synchronous) clears the frame state, the cached reading and both
// pipeline stages, and sets the bit length threshold to 100 ticks.
module single_wire_humidity_frame_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_edge_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_humidity,
  output logic signed [15:0] out_temperature,
  output logic [1:0]         out_status
);
  import swhfd_pkg::*;

  logic          advance;
  logic [15:0]   threshold_r;
  logic          s1_valid_r;
  logic [1:0]    s1_command_r;
  logic [15:0]   s1_edge_time_r;
  logic          res_valid;
  swhfd_result_t res;
  logic          out_valid_r;
  swhfd_result_t out_res_r;

  // Both stages move together unless a finished result is waiting to be taken.
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_command_r   <= in_command;
      s1_edge_time_r <= in_edge_time;
      if (res_valid) begin
        out_res_r <= res;
      end
    end
  end

  swhfd_edge_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_en   (s1_valid_r && advance),
    .command   (s1_command_r),
    .edge_time (s1_edge_time_r),
    .threshold (threshold_r),
    .res_valid (res_valid),
    .result    (res)
  );

  assign out_valid       = out_valid_r;
  assign out_humidity    = out_res_r.humidity;
  assign out_temperature = out_res_r.temperature;
  assign out_status      = out_res_r.status;

endmodule

// ----- hw/rtl/swhfd_checker.sv -----
module swhfd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_stall,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_humidity,
  input  logic signed [15:0] out_temperature,
  input  logic [1:0]         out_status
);
  import swhfd_pkg::*;

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_humidity)
      && $stable(out_temperature) && $stable(out_status))
    else $error("stalled result changed");

  // The input side is only held back by a waiting result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ERR_CHECKSUM)
      |-> (out_humidity == HUM_FAIL) && (out_temperature == TEMP_FAIL))
    else $error("checksum failure result malformed");

  // A fifteen-bit magnitude can never produce the most negative value.
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature != 16'sh8000)
      && ((out_status == ERR_NONE) || (out_status == ERR_EARLY)
        || (out_status == ERR_CHECKSUM)))
    else $error("result temperature or status out of range");

endmodule

bind single_wire_humidity_frame_decoder_core swhfd_checker u_swhfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_humidity    (out_humidity),
  .out_temperature (out_temperature),
  .out_status      (out_status)
);
